[hdl/sorted_set_insert_remove_top_macros.svh]
// Assertion macros for the sorted set block
`ifndef SORTED_SET_INSERT_REMOVE_TOP_MACROS_SVH
`define SORTED_SET_INSERT_REMOVE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSIR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted set: assertion failed");

// Next-cycle implication, disabled during reset
`define SSIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted set: assertion failed");

`endif

[hdl/ssir_pkg.sv]
// Shared types and constants for the sorted set block
package ssir_pkg;

    localparam int KEY_W        = 32;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 6;
    localparam int CAPACITY_DEF = 32;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic req_load;
        logic cmp_load;
        logic exec;
        logic dump_step;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              out_free;
        logic              dump_last;
    } t_stat;

endpackage

[hdl/ssir_ctrl.sv]
// Controller state machine for the sorted set block
module ssir_ctrl
    import ssir_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp_load = 1'b1;
                if (i_stat.kind == KIND_DUMP && !i_stat.empty) begin
                    n_state = S_DUMP;
                end else begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.req_load = 1'b1;
                        n_state        = S_CMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DUMP: begin
                if (i_stat.out_free) begin
                    o_cmd.dump_step = 1'b1;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/ssir_dp.sv]
// Datapath for the sorted set block: key cell row, comparators, result register
module ssir_dp
    import ssir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic signed [KEY_W-1:0]    i_key,
    input  logic                       i_out_ready,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    output logic                       o_out_valid,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [KEY_W-1:0]    o_value,
    output logic [COUNT_W-1:0]         o_count,
    output logic                       o_last
);

    localparam int USED_W = $clog2(CAPACITY + 1);

    logic [KIND_W-1:0]        r_kind;
    logic signed [KEY_W-1:0]  r_key;
    logic signed [KEY_W-1:0]  r_cell [CAPACITY];
    logic [USED_W-1:0]        r_used;
    logic [USED_W-1:0]        n_used;
    logic [CAPACITY-1:0]      r_lt;
    logic [CAPACITY-1:0]      r_eq;
    logic [USED_W-1:0]        r_dcnt;
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_status;
    logic signed [KEY_W-1:0]  r_value;
    logic [COUNT_W-1:0]       r_count;
    logic                     r_last;

    logic [CAPACITY-1:0]      w_lt;
    logic [CAPACITY-1:0]      w_eq;
    logic [CAPACITY-1:0]      w_top;
    logic signed [KEY_W-1:0]  w_ins  [CAPACITY];
    logic signed [KEY_W-1:0]  w_rem  [CAPACITY];
    logic signed [KEY_W-1:0]  w_rot  [CAPACITY];
    logic signed [KEY_W-1:0]  w_next [CAPACITY];
    logic [STATUS_W-1:0]      n_status;
    logic                     w_found;
    logic                     w_full;
    logic                     w_do_ins;
    logic                     w_do_rem;
    logic                     w_cell_we;
    logic                     w_dump_last;

    assign w_found = |r_eq;
    assign w_full  = (r_used == USED_W'(CAPACITY));

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic w_valid;
        assign w_valid  = (USED_W'(i) < r_used);
        assign w_lt[i]  = w_valid && (r_cell[i] < r_key);
        assign w_eq[i]  = w_valid && (r_cell[i] == r_key);
        assign w_top[i] = (USED_W'(i + 1) == r_used);

        if (i == 0) begin : g_first
            assign w_ins[i] = r_lt[i] ? r_cell[i] : r_key;
        end else begin : g_rest
            assign w_ins[i] = r_lt[i] ? r_cell[i] : (r_lt[i-1] ? r_key : r_cell[i-1]);
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_rem[i] = r_cell[i];
            assign w_rot[i] = w_top[i] ? r_cell[0] : r_cell[i];
        end else begin : g_mid
            assign w_rem[i] = r_lt[i] ? r_cell[i] : r_cell[i+1];
            assign w_rot[i] = w_top[i] ? r_cell[0] : r_cell[i+1];
        end

        assign w_next[i] = w_do_ins ? w_ins[i] : (w_do_rem ? w_rem[i] : w_rot[i]);
    end

    always_comb begin
        n_used   = r_used;
        n_status = ST_OK;
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        case (r_kind)
            KIND_INSERT: begin
                if (w_found) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_do_ins = i_cmd.exec;
                    n_used   = r_used + 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (w_found) begin
                    w_do_rem = i_cmd.exec;
                    n_used   = r_used - 1'b1;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            KIND_CLEAR: begin
                n_used = '0;
            end
            default: begin
                n_status = ST_EMPTY;
            end
        endcase
    end

    assign w_cell_we   = w_do_ins || w_do_rem || i_cmd.dump_step;
    assign w_dump_last = (USED_W'(r_dcnt + 1'b1) == r_used);

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_kind <= i_kind;
            r_key  <= i_key;
        end
        if (i_cmd.cmp_load) begin
            r_lt <= w_lt;
            r_eq <= w_eq;
        end
        if (w_cell_we) begin
            for (int j = 0; j < CAPACITY; j++) begin
                r_cell[j] <= w_next[j];
            end
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_value  <= '0;
            r_count  <= COUNT_W'(n_used);
            r_last   <= 1'b1;
        end else if (i_cmd.dump_step) begin
            r_status <= ST_OK;
            r_value  <= r_cell[0];
            r_count  <= COUNT_W'(r_used);
            r_last   <= w_dump_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_used <= n_used;
            end
            if (i_cmd.cmp_load) begin
                r_dcnt <= '0;
            end else if (i_cmd.dump_step) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (i_cmd.exec || i_cmd.dump_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.empty     = (r_used == '0);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.dump_last = w_dump_last;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_count     = r_count;
    assign o_last      = r_last;

endmodule

[hdl/sorted_set_insert_remove_top.sv]
// Sorted set of distinct signed keys: insert, remove, clear and dump requests.
// The keys live in a row of CAPACITY cells kept in ascending order; every cell
// compares its key against the request key in parallel, and the compare
// results are registered before the row shifts up (insert) or down (remove).
// Insert, remove and clear follow back to back: the CMP state registers the
// compare row, then RES shifts the row (insert or remove) and loads the result
// register. A dump of a non-empty set goes on to DUMP: the row rotates by one
// cell per cycle and cell 0 is sent out, so one key leaves per cycle while the
// output is free; a dump of an empty set ends in RES. A held result stalls the
// block only when the next result is due.
`include "sorted_set_insert_remove_top_macros.svh"

module sorted_set_insert_remove_top
    import ssir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic signed [KEY_W-1:0]  i_key,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [KEY_W-1:0]  o_value,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    ssir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ssir_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_count     (o_count),
        .o_last      (o_last)
    );

    `SSIR_ASSERT_IMPL(a_cmd_excl, 1'b1, $onehot0({w_cmd.cmp_load, w_cmd.exec, w_cmd.dump_step}))
    `SSIR_ASSERT_NEXT(a_busy_after_req, i_in_valid && o_in_ready, !o_in_ready)
    `SSIR_ASSERT_IMPL(a_mid_dump_ok, o_out_valid && !o_last, o_status == ST_OK)
    `SSIR_ASSERT_IMPL(a_empty_result, o_out_valid && o_status == ST_EMPTY, o_count == '0 && o_last)

endmodule
